/* sv/sobl_pkg.sv */
// Shared constants, types and the quarter-wave sine table for the sine beacon.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package sobl_pkg;

  // Phase accumulator and sine lookup geometry
  localparam int PHASE_BITS      = 32;
  localparam int SINE_INDEX_BITS = 10;
  localparam int QUARTER_SIZE    = 1 << SINE_INDEX_BITS;
  localparam int SINE_ENTRIES    = QUARTER_SIZE + 1;
  localparam int SINE_ADDR_W     = SINE_INDEX_BITS + 1;
  localparam int SINE_FRAC_BITS  = 16;
  localparam int SINE_MAG_W      = SINE_FRAC_BITS + 1;
  localparam int LEVEL_NUM_W     = SINE_FRAC_BITS + 2;

  // Field and register widths
  localparam int ELAPSED_W   = 16;
  localparam int FREQ_W      = 16;
  localparam int PEAK_W      = 8;
  localparam int OFFSET_W    = 8;
  localparam int LEVEL_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000);
  localparam logic [PEAK_W-1:0] PEAK_RESET = PEAK_W'(255);

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FREQ   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = CFG_INDEX_W'(2);

  // Shift-add multiplier, two multiplier bits per cycle
  localparam int MUL_A_W    = LEVEL_NUM_W;
  localparam int MUL_B_W    = ELAPSED_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CYCLES = MUL_B_W / 2;
  localparam int MUL_CNT_W  = $clog2(MUL_CYCLES + 1);

  // Restoring divider, two quotient bits per cycle. The dividend is the
  // numerator followed by PHASE_BITS zero bits; only the low PHASE_BITS
  // quotient bits are kept, which drops whole turns.
  localparam int NUM_W       = ELAPSED_W + FREQ_W;
  localparam int MICRO       = 1000000;
  localparam int PERCENT     = 100;
  localparam int DIVISOR_W   = $clog2(MICRO + 1);
  localparam int DIV_PAD     = (NUM_W + PHASE_BITS) % 2;
  localparam int DVD_W       = NUM_W + DIV_PAD;
  localparam int DIV_CYCLES  = (DVD_W + PHASE_BITS) / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);

  typedef struct packed {
    logic start;
    logic percent;  // divide by 100 instead of 10^6
  } div_ctrl_t;

  // Table build: Taylor series in Q30, rounded to Q16
  localparam int Q30_SHIFT = 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 8;
  localparam longint unsigned TAYLOR_DEN [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};
  localparam int MAG_SHIFT = Q30_SHIFT - SINE_FRAC_BITS;
  localparam longint unsigned MAG_ROUND = 64'd1 << (MAG_SHIFT - 1);
  localparam longint unsigned MAG_ONE   = 64'd1 << SINE_FRAC_BITS;

  typedef logic [SINE_MAG_W-1:0] sine_table_t [SINE_ENTRIES];

  function automatic sine_table_t build_sine_table();
    sine_table_t       tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   u;
    longint            sum;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) / QUARTER_SIZE;
      x2   = (x * x) >> Q30_SHIFT;
      term = x;
      sum  = longint'(x);
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
        term = ((term * x2) >> Q30_SHIFT) / TAYLOR_DEN[n];
        if ((n & 1) == 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        u = 64'd0;
      end else begin
        u = (longint'(sum) + MAG_ROUND) >> MAG_SHIFT;
      end
      if (u > MAG_ONE) begin
        u = MAG_ONE;
      end
      tab[k] = u[SINE_MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

/* sv/sobl_mul.sv */
// Digit-serial shift-add multiplier: two multiplier bits per cycle, MSB first.
// Uses sobl_pkg for widths; shared by the phase step and the brightness scale.
`default_nettype none

module sobl_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [sobl_pkg::MUL_A_W-1:0] a,
  input  wire logic [sobl_pkg::MUL_B_W-1:0] b,
  output logic      [sobl_pkg::MUL_P_W-1:0] prod,
  output logic                              done
);

  logic [sobl_pkg::MUL_A_W-1:0]   a1;
  logic [sobl_pkg::MUL_A_W+1:0]   a3;
  logic [sobl_pkg::MUL_B_W-1:0]   b_sh;
  logic [sobl_pkg::MUL_CNT_W-1:0] cnt;
  logic [sobl_pkg::MUL_P_W-1:0]   term;

  always_comb begin
    case (b_sh[sobl_pkg::MUL_B_W-1 -: 2])
      2'd0:    term = '0;
      2'd1:    term = sobl_pkg::MUL_P_W'(a1);
      2'd2:    term = sobl_pkg::MUL_P_W'({a1, 1'b0});
      default: term = sobl_pkg::MUL_P_W'(a3);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == sobl_pkg::MUL_CNT_W'(1));
      if (start) begin
        cnt <= sobl_pkg::MUL_CNT_W'(sobl_pkg::MUL_CYCLES);
      end else if (cnt != '0) begin
        cnt <= cnt - sobl_pkg::MUL_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a1   <= a;
      a3   <= {2'b00, a} + {1'b0, a, 1'b0};
      b_sh <= b;
      prod <= '0;
    end else if (cnt != '0) begin
      prod <= {prod[sobl_pkg::MUL_P_W-3:0], 2'b00} + term;
      b_sh <= {b_sh[sobl_pkg::MUL_B_W-3:0], 2'b00};
    end
  end

endmodule

`default_nettype wire

/* sv/sobl_div.sv */
// Radix-4 restoring divider (two compare-subtract steps per cycle) giving the
// fraction of a turn, numer * 2^PHASE_BITS / divisor mod one turn. Uses sobl_pkg.
`default_nettype none

module sobl_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire sobl_pkg::div_ctrl_t             ctrl,
  input  wire logic [sobl_pkg::NUM_W-1:0]      numer,
  output logic      [sobl_pkg::PHASE_BITS-1:0] quot,
  output logic                                 done
);

  localparam int RW = sobl_pkg::DIVISOR_W;

  logic [sobl_pkg::DVD_W-1:0]     dvd;
  logic [RW-1:0]                  rem;
  logic [RW-1:0]                  divisor;
  logic [sobl_pkg::DIV_CNT_W-1:0] cnt;
  logic [RW:0]                    t1;
  logic [RW:0]                    t2;
  logic [RW-1:0]                  r1;
  logic [RW-1:0]                  r2;
  logic                           b1;
  logic                           b2;

  always_comb begin
    t1 = {rem, dvd[sobl_pkg::DVD_W-1]};
    b1 = (t1 >= {1'b0, divisor});
    r1 = b1 ? RW'(t1 - {1'b0, divisor}) : t1[RW-1:0];
    t2 = {r1, dvd[sobl_pkg::DVD_W-2]};
    b2 = (t2 >= {1'b0, divisor});
    r2 = b2 ? RW'(t2 - {1'b0, divisor}) : t2[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == sobl_pkg::DIV_CNT_W'(1));
      if (ctrl.start) begin
        cnt <= sobl_pkg::DIV_CNT_W'(sobl_pkg::DIV_CYCLES);
      end else if (cnt != '0) begin
        cnt <= cnt - sobl_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // Every quotient bit gets shifted out of range before done, so no clear
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd     <= sobl_pkg::DVD_W'(numer);
      rem     <= '0;
      divisor <= ctrl.percent ? RW'(sobl_pkg::PERCENT) : RW'(sobl_pkg::MICRO);
    end else if (cnt != '0) begin
      dvd  <= {dvd[sobl_pkg::DVD_W-3:0], 2'b00};
      rem  <= r2;
      quot <= {quot[sobl_pkg::PHASE_BITS-3:0], b1, b2};
    end
  end

endmodule

`default_nettype wire

/* sv/sobl_sine_rom.sv */
// Quarter-wave sine magnitude ROM with registered read data.
// Contents come from sobl_pkg::SINE_TABLE, built at elaboration.
`default_nettype none

module sobl_sine_rom (
  input  wire logic                             clk,
  input  wire logic [sobl_pkg::SINE_ADDR_W-1:0] addr,
  output logic      [sobl_pkg::SINE_MAG_W-1:0]  data
);

  sobl_pkg::sine_table_t mem;

  assign mem = sobl_pkg::SINE_TABLE;

  always_ff @(posedge clk) begin
    data <= mem[addr];
  end

endmodule

`default_nettype wire

/* sv/sine_oscillating_beacon_light.sv */
// Sine beacon top level: phase accumulator, sequencer and output register.
// Depends on sobl_pkg, sobl_mul, sobl_div and sobl_sine_rom.
//
// Usage:
//   Tick channel (tick_valid/tick_stall) carries elapsed_ms and active; a beat
//   moves when valid is high and stall is low. Each tick yields one brightness
//   beat on the level channel (level_valid/level_stall).
//   An active tick runs the shared multiplier (elapsed_ms * frequency), the
//   radix-4 divider (fraction of a turn), a ROM read and a second multiplier
//   pass (peak scaling): the result is registered and, in S_PUT, moved to
//   the output register before the next tick is taken. An inactive tick
//   registers a 0 result, goes to S_PUT and leaves the phase alone.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken
//   while the sequencer is idle. Writing the phase offset runs the divider
//   and holds off ticks until the accumulator is loaded.
//   The output register frees the sequencer: a new tick may be taken while a
//   result waits; if the receiver still stalls when the next result is ready,
//   the sequencer holds it until the pending beat moves.
//   Reset (rst, synchronous) clears the phase, sets frequency to 1000 mHz and
//   peak to 255, and drops level_valid.
`default_nettype none

module sine_oscillating_beacon_light (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             tick_valid,
  output logic                                  tick_stall,
  input  wire logic [sobl_pkg::ELAPSED_W-1:0]   elapsed_ms,
  input  wire logic                             active,
  output logic                                  level_valid,
  input  wire logic                             level_stall,
  output logic      [sobl_pkg::LEVEL_W-1:0]     brightness,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sobl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sobl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_MUL_INC = 7'b0000010,
    S_DIV     = 7'b0000100,
    S_LOOK    = 7'b0001000,
    S_NUM     = 7'b0010000,
    S_MUL_OUT = 7'b0100000,
    S_PUT     = 7'b1000000
  } state_t;

  localparam int PB  = sobl_pkg::PHASE_BITS;
  localparam int SAW = sobl_pkg::SINE_ADDR_W;
  localparam int LNW = sobl_pkg::LEVEL_NUM_W;

  state_t                          state;
  state_t                          state_next;
  logic [sobl_pkg::FREQ_W-1:0]     freq;
  logic [sobl_pkg::PEAK_W-1:0]     peak;
  logic [PB-1:0]                   phase;
  logic                            offs_neg;
  logic                            div_offs;
  logic [sobl_pkg::LEVEL_W-1:0]    result;

  logic                            tick_acc;
  logic                            cfg_acc;
  logic                            offs_wr;
  logic                            out_free;
  logic [sobl_pkg::FREQ_W-1:0]     freq_eff;
  logic [sobl_pkg::OFFSET_W-1:0]   offs_val;
  logic [sobl_pkg::OFFSET_W-1:0]   offs_mag;

  logic                            mul_start;
  logic [sobl_pkg::MUL_A_W-1:0]    mul_a;
  logic [sobl_pkg::MUL_B_W-1:0]    mul_b;
  logic [sobl_pkg::MUL_P_W-1:0]    mul_prod;
  logic                            mul_done;

  sobl_pkg::div_ctrl_t             div_ctrl;
  logic [sobl_pkg::NUM_W-1:0]      div_numer;
  logic [PB-1:0]                   div_quot;
  logic                            div_done;

  logic [1:0]                      quadrant;
  logic [sobl_pkg::SINE_INDEX_BITS-1:0] k;
  logic [SAW-1:0]                  rom_addr;
  logic [sobl_pkg::SINE_MAG_W-1:0] rom_data;
  logic [LNW-1:0]                  level_num;

  // Handshakes
  assign cfg_ready  = (state == S_IDLE);
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign offs_wr    = cfg_acc && (cfg_index == sobl_pkg::REG_OFFSET);
  assign tick_stall = (state != S_IDLE) || (cfg_valid && (cfg_index == sobl_pkg::REG_OFFSET));
  assign tick_acc   = tick_valid && !tick_stall;
  assign out_free   = !level_valid || !level_stall;

  assign freq_eff = (freq == '0) ? sobl_pkg::FREQ_W'(1) : freq;
  assign offs_val = cfg_data[sobl_pkg::OFFSET_W-1:0];
  // Negative offsets divide the magnitude, then negate the fraction
  assign offs_mag = offs_val[sobl_pkg::OFFSET_W-1] ? (sobl_pkg::OFFSET_W'(0) - offs_val)
                                                   : offs_val;

  // Quarter-wave lookup: odd quadrants mirror the index
  assign quadrant = phase[PB-1 -: 2];
  assign k        = phase[PB-3 -: sobl_pkg::SINE_INDEX_BITS];
  assign rom_addr = quadrant[0] ? (SAW'(sobl_pkg::QUARTER_SIZE) - SAW'(k)) : SAW'(k);

  assign level_num = quadrant[1] ? (LNW'(sobl_pkg::MAG_ONE) - LNW'(rom_data))
                                 : (LNW'(sobl_pkg::MAG_ONE) + LNW'(rom_data));

  // Shared multiplier: phase step on an active tick, peak scaling in S_NUM
  assign mul_start = (tick_acc && active) || (state == S_NUM);
  assign mul_a     = (state == S_NUM) ? level_num : sobl_pkg::MUL_A_W'(freq_eff);
  assign mul_b     = (state == S_NUM) ? sobl_pkg::MUL_B_W'(peak) : elapsed_ms;

  assign div_ctrl.start   = ((state == S_MUL_INC) && mul_done) || offs_wr;
  assign div_ctrl.percent = offs_wr;
  assign div_numer = offs_wr ? sobl_pkg::NUM_W'(offs_mag) : mul_prod[sobl_pkg::NUM_W-1:0];

  sobl_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  sobl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (div_ctrl),
    .numer (div_numer),
    .quot  (div_quot),
    .done  (div_done)
  );

  sobl_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (offs_wr) begin
          state_next = S_DIV;
        end else if (tick_acc) begin
          state_next = active ? S_MUL_INC : S_PUT;
        end
      end
      S_MUL_INC: begin
        if (mul_done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = div_offs ? S_IDLE : S_LOOK;
        end
      end
      S_LOOK:    state_next = S_NUM;
      S_NUM:     state_next = S_MUL_OUT;
      S_MUL_OUT: begin
        if (mul_done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Control state, configuration, phase and level_valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      freq        <= sobl_pkg::FREQ_RESET;
      peak        <= sobl_pkg::PEAK_RESET;
      phase       <= '0;
      level_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        unique case (cfg_index)
          sobl_pkg::REG_FREQ: freq <= cfg_data[sobl_pkg::FREQ_W-1:0];
          sobl_pkg::REG_PEAK: peak <= cfg_data[sobl_pkg::PEAK_W-1:0];
          default: ;
        endcase
      end
      if ((state == S_DIV) && div_done) begin
        if (div_offs) begin
          phase <= offs_neg ? (PB'(0) - div_quot) : div_quot;
        end else begin
          phase <= phase + div_quot;
        end
      end
      if ((state == S_PUT) && out_free) begin
        level_valid <= 1'b1;
      end else if (level_valid && !level_stall) begin
        level_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && offs_wr) begin
      div_offs <= 1'b1;
      offs_neg <= offs_val[sobl_pkg::OFFSET_W-1];
    end else if (state == S_MUL_INC) begin
      div_offs <= 1'b0;
    end
    if ((state == S_IDLE) && tick_acc && !active) begin
      result <= '0;
    end else if ((state == S_MUL_OUT) && mul_done) begin
      result <= mul_prod[sobl_pkg::SINE_FRAC_BITS+1 +: sobl_pkg::LEVEL_W];
    end
    if ((state == S_PUT) && out_free) begin
      brightness <= result;
    end
  end

`ifndef SYNTH
  a_dark_tick: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && !active) |=> (state == S_PUT) && (result == '0) && $stable(phase))
    else $error("inactive tick did not give a dark result with the phase held");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_put_moves: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PUT) && out_free) |=> level_valid && (state == S_IDLE)
                                       && (brightness == $past(result)))
    else $error("finished result not moved into the output register");

  a_phase_quiet: assert property (@(posedge clk) disable iff (rst)
    ((state != S_DIV) && ($past(state) != S_DIV)) |-> $stable(phase))
    else $error("phase changed outside a divider completion");
`endif

endmodule

`default_nettype wire
